### hw/rtl/assert_macros.svh
// Assertion helpers for the pulse generator; clock and reset are i_clk / i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hw/rtl/etpg_pkg.sv
package etpg_pkg;

    // Request kinds
    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_THROTTLE = 2'd1,
        MODE_PULSE    = 2'd2,
        MODE_STOP     = 2'd3
    } t_mode;

    // Configuration register indexes
    localparam logic [2:0] CFG_MIN_PULSE     = 3'd0;
    localparam logic [2:0] CFG_NEUTRAL_PULSE = 3'd1;
    localparam logic [2:0] CFG_MAX_PULSE     = 3'd2;
    localparam logic [2:0] CFG_DEAD_BAND     = 3'd3;
    localparam logic [2:0] CFG_FRAME_PERIOD  = 3'd4;
    localparam logic [2:0] CFG_REVERSE       = 3'd5;
    localparam logic [2:0] CFG_ENABLE        = 3'd6;

    localparam int unsigned CFG_DATA_W = 17;

    // Reset values
    localparam logic [15:0] RST_MIN_PULSE     = 16'd1000;
    localparam logic [15:0] RST_NEUTRAL_PULSE = 16'd1500;
    localparam logic [15:0] RST_MAX_PULSE     = 16'd2000;
    localparam logic [15:0] RST_DEAD_BAND     = 16'd0;
    localparam logic [16:0] RST_FRAME_PERIOD  = 17'd20000;

    typedef struct packed {
        t_mode              mode;
        logic signed [15:0] throttle;
        logic        [15:0] pulse_request;
    } t_in_item;

    typedef struct packed {
        logic        pwm_out;
        logic [15:0] pulse_width;
        logic        frame_start;
    } t_out_item;

endpackage

### hw/rtl/esc_throttle_pulse_generator_core.sv
// Pulse generator for a hobby speed controller.
// Input channel (i_in_valid / o_in_ready / i_in_data): one request per item,
//   a 1 us tick, a Q1.THROTTLE_FRAC_BITS throttle command, a direct pulse
//   write or a stop. Every request yields exactly one result on the output
//   channel (o_out_valid / i_out_ready / o_out_data): pin level, pulse width
//   after the request, and a frame-start flag for ticks.
// Configuration (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) is
//   always ready; write it only while no request is in flight.
// Pipeline: a request moves from the input register to the result register
//   once that is free. Throughput: one request per cycle while the output
//   is not stalled; the whole mapping (base, span, one 16x17 multiply,
//   round, add or subtract) sits between the input register and the result
//   register; the frame counter and pulse state load with the result.
// Reset: synchronous, active low. Registers return to 1000/1500/2000 us,
//   dead band 0, 20000-tick frame, not reversed, disabled; both pipeline
//   stages empty.
// Stall: when i_out_ready is low the result holds and the input register
//   holds its request; o_in_ready drops only once both stages are full.
module esc_throttle_pulse_generator_core
    import etpg_pkg::*;
#(
    parameter int unsigned COUNTER_BITS       = 16,
    parameter int unsigned THROTTLE_FRAC_BITS = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Compare width wide enough for both the counter and the 17-bit period
    localparam int unsigned CMP_W = (COUNTER_BITS > 17) ? COUNTER_BITS : 17;
    localparam logic [31:0] ONE_Q  = 32'(1) << THROTTLE_FRAC_BITS;
    localparam logic [33:0] HALF_Q = 34'(1) << (THROTTLE_FRAC_BITS - 1);

    // Configuration registers
    logic [15:0] r_min, r_neutral, r_max, r_dead;
    logic [16:0] r_period;
    logic        r_reverse, r_enable;

    // Generator state
    logic [COUNTER_BITS-1:0] r_cnt, n_cnt;
    logic [15:0]             r_pulse, n_pulse;
    logic                    r_was_en;
    logic                    r_last, n_last;

    // Pipeline
    logic      r_s1_valid;
    t_in_item  r_s1;
    logic      r_out_valid;
    t_out_item r_out, n_out;

    logic out_free, s1_fire;

    assign out_free    = !r_out_valid || i_out_ready;
    assign s1_fire     = r_s1_valid && out_free;
    assign o_in_ready  = !r_s1_valid || out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min     <= RST_MIN_PULSE;
            r_neutral <= RST_NEUTRAL_PULSE;
            r_max     <= RST_MAX_PULSE;
            r_dead    <= RST_DEAD_BAND;
            r_period  <= RST_FRAME_PERIOD;
            r_reverse <= 1'b0;
            r_enable  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_PULSE:     r_min     <= i_cfg_data[15:0];
                CFG_NEUTRAL_PULSE: r_neutral <= i_cfg_data[15:0];
                CFG_MAX_PULSE:     r_max     <= i_cfg_data[15:0];
                CFG_DEAD_BAND:     r_dead    <= i_cfg_data[15:0];
                CFG_FRAME_PERIOD:  r_period  <= i_cfg_data;
                CFG_REVERSE:       r_reverse <= i_cfg_data[0];
                CFG_ENABLE:        r_enable  <= i_cfg_data[0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // Throttle mapping: sign, magnitude, base and span on each side
    logic signed [16:0] thr_ext, thr_adj;
    logic               thr_neg, thr_zero;
    logic [16:0]        thr_mag, mag_c;
    logic [16:0]        pos_sum;
    logic [15:0]        pos_base, neg_base, pos_span, neg_span, base, span;
    logic [32:0]        prod;
    logic [33:0]        rounded, scaled_w;
    logic [15:0]        scaled, thr_pulse, req_pulse;

    always_comb begin
        thr_ext  = 17'(r_s1.throttle);
        thr_adj  = r_reverse ? -thr_ext : thr_ext;
        thr_neg  = thr_adj[16];
        thr_zero = (thr_adj == '0);
        thr_mag  = thr_neg ? 17'(-thr_adj) : 17'(thr_adj);
        // clamp to +-1.0
        mag_c    = (32'(thr_mag) > ONE_Q) ? ONE_Q[16:0] : thr_mag;

        // saturate neutral + dead band at full scale, neutral - dead band at 0
        pos_sum  = {1'b0, r_neutral} + {1'b0, r_dead};
        pos_base = pos_sum[16] ? 16'hFFFF : pos_sum[15:0];
        neg_base = (r_neutral > r_dead) ? (r_neutral - r_dead) : 16'd0;
        pos_span = (r_max > pos_base) ? (r_max - pos_base) : 16'd0;
        neg_span = (neg_base > r_min) ? (neg_base - r_min) : 16'd0;
        base     = thr_neg ? neg_base : pos_base;
        span     = thr_neg ? neg_span : pos_span;

        // round half up; the scaled value never exceeds the span
        prod     = {17'd0, span} * {16'd0, mag_c};
        rounded  = {1'b0, prod} + HALF_Q;
        scaled_w = rounded >> THROTTLE_FRAC_BITS;
        scaled   = scaled_w[15:0];

        if (thr_zero) begin
            thr_pulse = r_neutral;
        end else if (thr_neg) begin
            thr_pulse = base - scaled;
        end else begin
            thr_pulse = base + scaled;
        end

        // direct write: with inverted limits, a request below the lower limit gets it, any other the upper one
        if (r_s1.pulse_request < r_min) begin
            req_pulse = r_min;
        end else if (r_s1.pulse_request > r_max) begin
            req_pulse = r_max;
        end else begin
            req_pulse = r_s1.pulse_request;
        end
    end

    // Per-request state update and result
    logic                    en_rise, level, fstart;
    logic [COUNTER_BITS-1:0] cnt_cur, cnt_inc;
    logic [15:0]             pulse_cur;

    always_comb begin
        en_rise   = r_enable && !r_was_en;
        cnt_cur   = en_rise ? '0 : r_cnt;
        pulse_cur = en_rise ? r_neutral : r_pulse;
        cnt_inc   = cnt_cur + 1'b1;
        n_cnt     = cnt_cur;
        n_pulse   = pulse_cur;
        n_last    = r_last;
        level     = 1'b0;
        fstart    = 1'b0;

        if (!r_enable) begin
            n_last = 1'b0;
        end else begin
            case (r_s1.mode)
                MODE_TICK: begin
                    level  = (CMP_W'(cnt_cur) < CMP_W'(pulse_cur));
                    fstart = (cnt_cur == '0);
                    n_cnt  = (CMP_W'(cnt_inc) >= CMP_W'(r_period)) ? '0 : cnt_inc;
                    n_last = level;
                end
                MODE_THROTTLE: begin
                    n_pulse = thr_pulse;
                    level   = r_last;
                end
                MODE_PULSE: begin
                    n_pulse = req_pulse;
                    level   = r_last;
                end
                default: begin  // stop
                    n_pulse = r_neutral;
                    level   = r_last;
                end
            endcase
        end

        n_out.pwm_out     = level;
        n_out.pulse_width = n_pulse;
        n_out.frame_start = fstart;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_pulse     <= RST_NEUTRAL_PULSE;
            r_was_en    <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            // input register: load on accept, empty once passed on
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            // result register: load on advance, clear once taken
            if (s1_fire) begin
                r_out_valid <= 1'b1;
                r_cnt       <= n_cnt;
                r_pulse     <= n_pulse;
                r_was_en    <= r_enable;
                r_last      <= n_last;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1 <= i_in_data;
        end
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

`include "assert_macros.svh"

    `ASSERT_CLK(a_disabled_low, s1_fire && !r_enable |=> !o_out_data.pwm_out && !o_out_data.frame_start, "disabled request drove the pin")
    `ASSERT_CLK(a_write_in_limits, s1_fire && r_enable && r_s1.mode == MODE_PULSE && r_min <= r_max |=> r_pulse >= r_min && r_pulse <= r_max, "direct write outside limits")
    `ASSERT_CLK(a_cnt_wraps, s1_fire && r_enable && r_s1.mode == MODE_TICK |=> r_cnt == '0 || CMP_W'(r_cnt) < CMP_W'(r_period), "frame counter past period")
    `ASSERT_ALWAYS(a_ready_when_empty, !r_s1_valid |-> o_in_ready, "input stalled while empty")

endmodule
